FILE: hdl/bfph_pkg.sv
// shared types and constants for the bloom filter with polynomial hashes
package bfph_pkg;

   localparam int DEF_NUM_WORDS  = 1024;
   localparam int DEF_MAX_HASHES = 8;

   localparam int CHAR_W        = 8;
   localparam int NUM_WORDS_W   = 11;
   localparam int HASH_COUNT_W  = 4;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 11;
   localparam int WORD_W        = 64;
   localparam int BIT_IDX_W     = 6;
   localparam int DIV_STEPS     = WORD_W - BIT_IDX_W;
   localparam int DIV_CNT_W     = 6;
   localparam int BYTE_OFFSET   = 96;

   localparam logic [NUM_WORDS_W-1:0]  NUM_WORDS_RESET  = NUM_WORDS_W'(1024);
   localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RESET = HASH_COUNT_W'(3);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_WORDS  = 1'b0,
      CSR_HASH_COUNT = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC,
      ST_LANE,
      ST_DIV,
      ST_READ,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic acc_en;
      logic lane_clr;
      logic div_start;
      logic div_step;
      logic update;
      logic lane_inc;
      logic out_load;
      logic restart;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic last;
      logic lane_more;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

FILE: hdl/bfph_req_if.sv
// request channel carrying one key character
interface bfph_req_if import bfph_pkg::*;;
   logic              valid;
   logic              ready;
   logic              func;
   logic [CHAR_W-1:0] char_code;
   logic              last;

   modport source (output valid, func, char_code, last, input ready);
   modport sink (input valid, func, char_code, last, output ready);
endinterface

FILE: hdl/bfph_rsp_if.sv
// response channel carrying the answer for one key
interface bfph_rsp_if;
   logic valid;
   logic ready;
   logic found;
   logic was_check;

   modport source (output valid, found, was_check, input ready);
   modport sink (input valid, found, was_check, output ready);
endinterface

FILE: hdl/bfph_csr_if.sv
// register write channel
interface bfph_csr_if import bfph_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/bfph_ram.sv
// generic single-port-write ram with registered read
module bfph_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: hdl/bfph_ctrl.sv
// sequencer for key hashing, reduction and bit probes
module bfph_ctrl import bfph_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_ACC;
         ST_ACC:    state_in = status.last ? ST_LANE : ST_IDLE;
         ST_LANE:   state_in = status.lane_more ? ST_DIV : ST_DONE;
         ST_DIV:    if (status.div_last) state_in = ST_READ;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_LANE;
         ST_DONE:   if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear_en = 1'b1;
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_ACC: begin
            cmd.acc_en   = 1'b1;
            cmd.lane_clr = 1'b1;
         end
         ST_LANE:   cmd.div_start = status.lane_more;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_READ:   cmd = '0;
         ST_UPDATE: begin
            cmd.update   = 1'b1;
            cmd.lane_inc = 1'b1;
         end
         ST_DONE: begin
            cmd.out_load = status.out_free;
            cmd.restart  = status.out_free;
         end
         default: cmd = '0;
      endcase
   end
endmodule

FILE: hdl/bfph_datapath.sv
// hash lanes, modulo unit, bit store access and response register
module bfph_datapath import bfph_pkg::*; #(
   parameter int NUM_WORDS  = DEF_NUM_WORDS,
   parameter int MAX_HASHES = DEF_MAX_HASHES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_func,
   input  logic [CHAR_W-1:0]     req_char,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic                  rsp_was_check
);
   localparam int AW    = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
   localparam int WDW   = $clog2(NUM_WORDS + 1);
   localparam int NWCMP = WDW > NUM_WORDS_W ? WDW : NUM_WORDS_W;
   localparam int LW    = MAX_HASHES > 1 ? $clog2(MAX_HASHES) : 1;
   localparam int CW    = $clog2(MAX_HASHES + 1);
   localparam int CMPW  = CW > HASH_COUNT_W ? CW : HASH_COUNT_W;

   logic [NUM_WORDS_W-1:0]  num_words_ff;
   logic [HASH_COUNT_W-1:0] hash_count_ff;
   logic [WDW-1:0]          words_eff;
   logic [CW-1:0]           count_eff;
   logic [NWCMP-1:0]        nw_x;
   logic [CMPW-1:0]         hc_x;

   logic [8:0]              term;
   logic                    neg;
   logic [CHAR_W-1:0]       mag;
   logic                    neg_ff;
   logic                    last_ff;
   logic                    func_ff;
   logic [WORD_W-1:0]       accum_ff [MAX_HASHES];
   logic [WORD_W-1:0]       power_ff [MAX_HASHES];
   logic [WORD_W-1:0]       prod_ff  [MAX_HASHES];

   logic [CW-1:0]           lane_ff;
   logic [DIV_STEPS-1:0]    dividend_ff;
   logic [BIT_IDX_W-1:0]    bitpos_ff;
   logic [WDW-1:0]          rem_ff;
   logic [DIV_CNT_W-1:0]    cnt_ff;
   logic [WDW:0]            trial;
   logic [WORD_W-1:0]       lane_hash;

   logic [AW-1:0]           clr_ff;
   logic                    found_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_found_ff;
   logic                    rsp_was_check_ff;

   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [AW-1:0]           ram_raddr;
   logic [WORD_W-1:0]       ram_wdata;
   logic [WORD_W-1:0]       ram_rdata;
   logic [WORD_W-1:0]       mask;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_words_ff  <= NUM_WORDS_RESET;
         hash_count_ff <= HASH_COUNT_RESET;
      end else if (csr_write) begin
         case (csr_idx_type'(csr_index))
            CSR_NUM_WORDS:  num_words_ff  <= csr_data;
            CSR_HASH_COUNT: hash_count_ff <= csr_data[HASH_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the register values
   always_comb begin
      nw_x = NWCMP'(num_words_ff);
      if (nw_x == '0) begin
         words_eff = WDW'(1);
      end else if (nw_x > NWCMP'(NUM_WORDS)) begin
         words_eff = WDW'(NUM_WORDS);
      end else begin
         words_eff = nw_x[WDW-1:0];
      end
      hc_x = CMPW'(hash_count_ff);
      if (hc_x > CMPW'(MAX_HASHES)) begin
         count_eff = CW'(MAX_HASHES);
      end else begin
         count_eff = hc_x[CW-1:0];
      end
   end

   // signed character minus offset, as sign and magnitude
   always_comb begin
      term = {req_char[CHAR_W-1], req_char} - 9'(BYTE_OFFSET);
      neg  = term[8];
      mag  = neg ? CHAR_W'(-term) : term[CHAR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         neg_ff  <= neg;
         last_ff <= req_last;
         func_ff <= req_func;
      end
   end

   for (genvar g = 0; g < MAX_HASHES; g++) begin : g_lane
      localparam logic [WORD_W-1:0] SEED = WORD_W'(g);

      always_ff @(posedge clock) begin
         if (cmd.accept) begin
            prod_ff[g] <= power_ff[g] * {{(WORD_W-CHAR_W){1'b0}}, mag};
         end
      end

      always_ff @(posedge clock) begin
         if (reset || cmd.restart) begin
            accum_ff[g] <= '0;
            power_ff[g] <= WORD_W'(1);
         end else if (cmd.acc_en) begin
            accum_ff[g] <= neg_ff ? accum_ff[g] - prod_ff[g] : accum_ff[g] + prod_ff[g];
            power_ff[g] <= power_ff[g] * SEED;
         end
      end
   end

   // lane sequencing and bit-serial modulo by the word count
   assign lane_hash = accum_ff[lane_ff[LW-1:0]];
   assign trial     = {rem_ff, dividend_ff[DIV_STEPS-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else if (cmd.lane_clr) begin
         lane_ff <= '0;
      end else if (cmd.lane_inc) begin
         lane_ff <= lane_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dividend_ff <= lane_hash[WORD_W-1:BIT_IDX_W];
         bitpos_ff   <= lane_hash[BIT_IDX_W-1:0];
         rem_ff      <= '0;
         cnt_ff      <= '0;
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, words_eff}) begin
            rem_ff <= WDW'(trial - {1'b0, words_eff});
         end else begin
            rem_ff <= trial[WDW-1:0];
         end
         dividend_ff <= {dividend_ff[DIV_STEPS-2:0], 1'b0};
         cnt_ff      <= cnt_ff + DIV_CNT_W'(1);
      end
   end

   // bit store
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   assign mask      = WORD_W'(1) << bitpos_ff;
   assign ram_raddr = rem_ff[AW-1:0];
   assign ram_we    = cmd.clear_en || (cmd.update && !func_ff);
   assign ram_waddr = cmd.clear_en ? clr_ff : ram_raddr;
   assign ram_wdata = cmd.clear_en ? '0 : (ram_rdata | mask);

   bfph_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_WORDS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         found_ff <= 1'b1;
      end else if (cmd.update && func_ff && !ram_rdata[bitpos_ff]) begin
         found_ff <= 1'b0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_found_ff     <= found_ff;
         rsp_was_check_ff <= func_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_was_check = rsp_was_check_ff;

   assign status.clear_done = clr_ff == AW'(NUM_WORDS - 1);
   assign status.last       = last_ff;
   assign status.lane_more  = lane_ff < count_eff;
   assign status.div_last   = cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
endmodule

FILE: hdl/bloom_filter_poly_hash.sv
// top level of the bloom filter with polynomial hashes
// A key arrives one character per request; a character that does not end the key is
// multiplied, then accumulated in all hash lanes at once. For the last character, each
// probed hash is reduced by a bit-serial modulo unit, followed by a read of the bit
// store ram and, for an insert, a read-modify-write of it. After reset the bit store is
// cleared one word per cycle, during which no request is taken; register writes are
// accepted at any time.
module bloom_filter_poly_hash import bfph_pkg::*; #(
   parameter int NUM_WORDS  = DEF_NUM_WORDS,
   parameter int MAX_HASHES = DEF_MAX_HASHES
) (
   input logic         clock,
   input logic         reset,
   bfph_req_if.sink    req_ch,
   bfph_rsp_if.source  rsp_ch,
   bfph_csr_if.sink    csr_ch
);
   cmd_type    cmd;
   status_type status;

   assign csr_ch.ready = 1'b1;

   bfph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bfph_datapath #(
      .NUM_WORDS  (NUM_WORDS),
      .MAX_HASHES (MAX_HASHES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_write     (csr_ch.valid),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data),
      .req_func      (req_ch.func),
      .req_char      (req_ch.char_code),
      .req_last      (req_ch.last),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_found     (rsp_ch.found),
      .rsp_was_check (rsp_ch.was_check)
   );
endmodule

FILE: hdl/bfph_checker.sv
// port-level assertions for the bloom filter, bound to the top level
module bfph_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_found,
   input logic rsp_was_check
);
   // one character in flight at a time
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken back to back");

   // an insert always answers found
   a_insert_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_check |-> rsp_found)
      else $error("insert answered not found");

   // a new response is never loaded while requests are open
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared while idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_was_check))
      else $error("stalled response changed");
endmodule

bind bloom_filter_poly_hash bfph_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_found     (rsp_ch.found),
   .rsp_was_check (rsp_ch.was_check)
);
